FILE: hdl/tscm_pkg.sv
// Shared package of the tile slot cache manager.
// Sizes, slot and result codes, and the command and status structs that join
// the controller and the datapath. Depends on nothing.
package tscm_pkg;

  localparam int SLOTS       = 64;
  localparam int CONTEXTS    = 32;
  localparam int QUEUE_DEPTH = 128;

  localparam int SW        = $clog2(SLOTS);
  localparam int QW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int INIT_FILL = (SLOTS < QUEUE_DEPTH) ? SLOTS : QUEUE_DEPTH;
  localparam int FW        = $clog2(INIT_FILL + 1);
  localparam int RCW       = $clog2(CONTEXTS + 1);
  localparam int NIBS      = (CONTEXTS + 3) / 4;

  localparam logic [2:0] NIBBLE_BITS [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  localparam logic [2:0] K_READ    = 3'd0;
  localparam logic [2:0] K_WRITE   = 3'd1;
  localparam logic [2:0] K_REG     = 3'd2;
  localparam logic [2:0] K_RELEASE = 3'd3;
  localparam logic [2:0] K_UNREG   = 3'd4;

  localparam logic [2:0] RS_OK          = 3'd0;
  localparam logic [2:0] RS_NOT_FOUND   = 3'd1;
  localparam logic [2:0] RS_NO_SLOT     = 3'd2;
  localparam logic [2:0] RS_WRONG_STATE = 3'd3;
  localparam logic [2:0] RS_BAD_CONTEXT = 3'd4;
  localparam logic [2:0] RS_QUEUE_FULL  = 3'd5;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_WRITING  = 2'd1,
    ST_OCCUPIED = 2'd2,
    ST_READING  = 2'd3
  } slot_st_t;

  typedef struct packed {
    slot_st_t              st;
    logic                  mapped;
    logic [CONTEXTS-1:0]   mask;
  } info_t;

  typedef struct packed {
    logic [7:0]  res;
    logic [63:0] tile;
  } key_t;

  typedef enum logic [2:0] {
    WOP_NONE    = 3'd0,
    WOP_READ    = 3'd1,
    WOP_RELEASE = 3'd2,
    WOP_UNMAP   = 3'd3,
    WOP_REG     = 3'd4,
    WOP_TAKE    = 3'd5
  } wop_t;

  typedef struct packed {
    logic       latch;
    logic       scan_clr;
    logic       scan_run;
    logic       skip_c;
    logic       key_ld;
    logic       rd_c;
    logic       fifo_pop;
    logic       c_ld;
    logic       cinfo_ld;
    wop_t       wop;
    logic       st_ld;
    logic [2:0] st_code;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       sidx_bad;
    logic       fifo_empty;
    logic       cand_bad;
    slot_st_t   cur_st;
    logic       scan_hit;
    logic       scan_end;
  } sts_t;

endpackage

FILE: hdl/tscm_datapath.sv
// Datapath of the tile slot cache manager: slot info and key memories,
// key scan, replacement FIFO, update logic and result registers.
// Depends on tscm_pkg.
module tscm_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_resource_id,
  input  logic [63:0]        in_tile_id,
  input  logic [5:0]         in_slot_index,
  input  logic [5:0]         in_context_id,
  input  tscm_pkg::cmd_t     cmd,
  output tscm_pkg::sts_t     sts,
  output logic [2:0]         out_status,
  output logic [5:0]         out_slot_index_res,
  output logic [5:0]         out_reader_count
);

  localparam int SW = tscm_pkg::SW;
  localparam int QW = tscm_pkg::QW;
  localparam int CW = tscm_pkg::CW;
  localparam int FW = tscm_pkg::FW;
  localparam int CX = tscm_pkg::CONTEXTS;

  tscm_pkg::info_t info_mem [tscm_pkg::SLOTS];
  tscm_pkg::key_t  key_mem  [tscm_pkg::SLOTS];
  logic [SW-1:0]   fifo_mem [tscm_pkg::QUEUE_DEPTH];

  logic [tscm_pkg::SLOTS-1:0] valid_r;
  tscm_pkg::info_t info_q_r;
  tscm_pkg::key_t  key_q_r;
  logic            vq_r;

  logic [2:0]      kind_r;
  logic [5:0]      ctx_r;
  logic            sidx_bad_r;
  tscm_pkg::key_t  skey_r;
  logic [SW-1:0]   c_r;
  tscm_pkg::info_t cinfo_r;
  logic [SW-1:0]   h_r;
  tscm_pkg::info_t hinfo_r;
  logic            hv_r;
  logic [SW:0]     scan_cnt_r;
  logic            cmp_v_r;
  logic [SW-1:0]   cmp_idx_r;

  logic [QW-1:0]   head_r;
  logic [CW-1:0]   cnt_r;
  logic [FW-1:0]   fill_r;
  logic [SW-1:0]   fq_mem_r;
  logic [QW-1:0]   fq_hd_r;
  logic            fq_init_r;

  logic [2:0]      st_r;
  logic [SW-1:0]   slot_r;
  logic [CX-1:0]   rmask_r;

  logic            issue;
  logic            rd_en;
  logic [SW-1:0]   rd_addr;
  tscm_pkg::info_t ie;
  logic [SW-1:0]   fifo_q;
  logic            scan_hit;
  logic            fifo_full;
  logic [QW-1:0]   tail;
  logic [QW-1:0]   head_inc;
  logic [CX-1:0]   cbit;
  logic            ctx_bad;

  logic            wr_en;
  logic [SW-1:0]   wr_addr;
  tscm_pkg::info_t wr_data;
  logic            key_we;
  logic            push;
  logic [SW-1:0]   push_val;
  logic            res_ld;
  logic [2:0]      st_res;
  logic [SW-1:0]   slot_res;
  logic [CX-1:0]   mask_res;
  logic [CX-1:0]   nm;

  logic [tscm_pkg::NIBS*4-1:0] padv;
  logic [tscm_pkg::RCW-1:0]    pc;

  assign issue   = cmd.scan_run && (scan_cnt_r < (SW+1)'(tscm_pkg::SLOTS));
  assign rd_en   = issue || cmd.rd_c;
  assign rd_addr = cmd.rd_c ? c_r : scan_cnt_r[SW-1:0];
  assign ie      = vq_r ? info_q_r : '0;
  assign fifo_q  = fq_init_r ? SW'(fq_hd_r) : fq_mem_r;
  assign scan_hit = cmp_v_r && ie.mapped && (key_q_r == skey_r)
                    && !(cmd.skip_c && (cmp_idx_r == c_r));
  assign fifo_full = (cnt_r == CW'(tscm_pkg::QUEUE_DEPTH));
  assign ctx_bad   = (32'(ctx_r) >= 32'(CX));

  always_comb begin
    int t;
    t = int'(head_r) + int'(cnt_r);
    if (t >= tscm_pkg::QUEUE_DEPTH) begin
      t = t - tscm_pkg::QUEUE_DEPTH;
    end
    tail = QW'(t);
    head_inc = (head_r == QW'(tscm_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
  end

  always_comb begin
    for (int j = 0; j < CX; j++) begin
      cbit[j] = (ctx_r == 6'(j));
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = h_r;
    wr_data  = hinfo_r;
    key_we   = 1'b0;
    push     = 1'b0;
    push_val = h_r;
    res_ld   = 1'b0;
    st_res   = tscm_pkg::RS_OK;
    slot_res = h_r;
    mask_res = '0;
    nm       = '0;
    case (cmd.wop)
      tscm_pkg::WOP_READ: begin
        res_ld = 1'b1;
        if (ctx_bad) begin
          st_res = tscm_pkg::RS_BAD_CONTEXT;
        end else begin
          nm          = hinfo_r.mask | cbit;
          wr_en       = 1'b1;
          wr_data.st  = tscm_pkg::ST_READING;
          wr_data.mask = nm;
          mask_res    = nm;
        end
      end
      tscm_pkg::WOP_RELEASE: begin
        res_ld = 1'b1;
        if (hinfo_r.st != tscm_pkg::ST_READING) begin
          st_res = tscm_pkg::RS_WRONG_STATE;
        end else if (ctx_bad) begin
          st_res = tscm_pkg::RS_BAD_CONTEXT;
        end else begin
          nm           = hinfo_r.mask & ~cbit;
          wr_en        = 1'b1;
          wr_data.mask = nm;
          mask_res     = nm;
          if (nm == '0) begin
            wr_data.st = tscm_pkg::ST_OCCUPIED;
            push       = !fifo_full;
            if (fifo_full) begin
              st_res = tscm_pkg::RS_QUEUE_FULL;
            end
          end
        end
      end
      tscm_pkg::WOP_UNMAP: begin
        res_ld         = 1'b1;
        wr_en          = 1'b1;
        wr_data.mapped = 1'b0;
        mask_res       = hinfo_r.mask;
      end
      tscm_pkg::WOP_REG: begin
        res_ld         = 1'b1;
        wr_en          = 1'b1;
        wr_addr        = c_r;
        wr_data        = cinfo_r;
        wr_data.st     = tscm_pkg::ST_OCCUPIED;
        wr_data.mapped = !hv_r;
        key_we         = 1'b1;
        push           = !fifo_full;
        push_val       = c_r;
        slot_res       = c_r;
        mask_res       = cinfo_r.mask;
        if (fifo_full) begin
          st_res = tscm_pkg::RS_QUEUE_FULL;
        end
      end
      tscm_pkg::WOP_TAKE: begin
        res_ld         = 1'b1;
        wr_en          = 1'b1;
        wr_addr        = c_r;
        wr_data.st     = tscm_pkg::ST_WRITING;
        wr_data.mapped = (hv_r && (h_r == c_r)) ? 1'b0 : cinfo_r.mapped;
        wr_data.mask   = '0;
        slot_res       = c_r;
      end
      default: begin
      end
    endcase
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      info_mem[wr_addr] <= wr_data;
    end
    if (key_we) begin
      key_mem[c_r] <= skey_r;
    end
    if (rd_en) begin
      info_q_r <= info_mem[rd_addr];
      key_q_r  <= key_mem[rd_addr];
      vq_r     <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // replacement FIFO
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail] <= push_val;
    end
    if (cmd.fifo_pop) begin
      fq_mem_r  <= fifo_mem[head_r];
      fq_hd_r   <= head_r;
      fq_init_r <= (int'(head_r) < tscm_pkg::INIT_FILL) && (int'(head_r) >= int'(fill_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= CW'(tscm_pkg::INIT_FILL);
      fill_r <= '0;
    end else if (cmd.fifo_pop) begin
      head_r <= head_inc;
      cnt_r  <= cnt_r - CW'(1);
    end else if (push) begin
      cnt_r <= cnt_r + CW'(1);
      if ((int'(fill_r) < tscm_pkg::INIT_FILL) && (int'(tail) == int'(fill_r))) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      cmp_v_r    <= 1'b0;
      hv_r       <= 1'b0;
    end else begin
      cmp_v_r <= issue;
      if (cmd.scan_clr) begin
        scan_cnt_r <= '0;
        hv_r       <= 1'b0;
      end else begin
        if (issue) begin
          scan_cnt_r <= scan_cnt_r + (SW+1)'(1);
        end
        if (cmd.scan_run && scan_hit) begin
          hv_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_cnt_r[SW-1:0];
    if (cmd.scan_run && scan_hit) begin
      h_r     <= cmp_idx_r;
      hinfo_r <= ie;
    end
    if (cmd.latch) begin
      kind_r     <= in_kind;
      ctx_r      <= in_context_id;
      sidx_bad_r <= (32'(in_slot_index) >= 32'(tscm_pkg::SLOTS));
      skey_r     <= '{res: in_resource_id, tile: in_tile_id};
      c_r        <= SW'(in_slot_index);
    end else begin
      if (cmd.key_ld) begin
        skey_r <= key_q_r;
      end
      if (cmd.c_ld) begin
        c_r <= fifo_q;
      end
    end
    if (cmd.cinfo_ld) begin
      cinfo_r <= ie;
    end
    if (cmd.st_ld) begin
      st_r <= cmd.st_code;
    end else if (res_ld) begin
      st_r    <= st_res;
      slot_r  <= slot_res;
      rmask_r <= mask_res;
    end
  end

  always_comb begin
    padv = '0;
    padv[CX-1:0] = rmask_r;
    pc = '0;
    for (int n = 0; n < tscm_pkg::NIBS; n++) begin
      pc = pc + tscm_pkg::RCW'(tscm_pkg::NIBBLE_BITS[padv[n*4 +: 4]]);
    end
  end

  assign sts.kind       = kind_r;
  assign sts.sidx_bad   = sidx_bad_r;
  assign sts.fifo_empty = (cnt_r == '0);
  assign sts.cand_bad   = (32'(fifo_q) >= 32'(tscm_pkg::SLOTS));
  assign sts.cur_st     = ie.st;
  assign sts.scan_hit   = scan_hit;
  assign sts.scan_end   = cmp_v_r && (cmp_idx_r == SW'(tscm_pkg::SLOTS - 1));

  assign out_status         = st_r;
  assign out_slot_index_res = (st_r == tscm_pkg::RS_OK) ? 6'(slot_r) : 6'd0;
  assign out_reader_count   = (st_r == tscm_pkg::RS_OK) ? 6'(pc) : 6'd0;

endmodule

FILE: hdl/tscm_ctrl.sv
// Controller of the tile slot cache manager: sequences scan, FIFO pops,
// slot reads and updates for each transaction.
// Depends on tscm_pkg.
module tscm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tscm_pkg::sts_t  sts,
  output tscm_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_strobe
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DISP  = 11'b000_0000_0010,
    S_SCAN  = 11'b000_0000_0100,
    S_POP   = 11'b000_0000_1000,
    S_CAND  = 11'b000_0001_0000,
    S_RDC   = 11'b000_0010_0000,
    S_CHK   = 11'b000_0100_0000,
    S_EVICT = 11'b000_1000_0000,
    S_TAKE  = 11'b001_0000_0000,
    S_APPLY = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch    = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.kind)
          tscm_pkg::K_READ, tscm_pkg::K_RELEASE, tscm_pkg::K_UNREG: state_nxt = S_SCAN;
          tscm_pkg::K_WRITE: state_nxt = S_POP;
          tscm_pkg::K_REG: begin
            if (sts.sidx_bad) begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = tscm_pkg::RS_WRONG_STATE;
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_RDC;
            end
          end
          default: begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = tscm_pkg::RS_WRONG_STATE;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.skip_c   = (sts.kind == tscm_pkg::K_REG);
        if (sts.scan_hit || sts.scan_end) begin
          case (sts.kind)
            tscm_pkg::K_WRITE: state_nxt = sts.scan_hit ? S_EVICT : S_TAKE;
            tscm_pkg::K_REG:   state_nxt = S_APPLY;
            default: begin
              if (sts.scan_hit) begin
                state_nxt = S_APPLY;
              end else begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tscm_pkg::RS_NOT_FOUND;
                state_nxt   = S_DONE;
              end
            end
          endcase
        end
      end
      S_POP: begin
        if (sts.fifo_empty) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = tscm_pkg::RS_NO_SLOT;
          state_nxt   = S_DONE;
        end else begin
          cmd.fifo_pop = 1'b1;
          state_nxt    = S_CAND;
        end
      end
      S_CAND: begin
        if (sts.cand_bad) begin
          state_nxt = S_POP;
        end else begin
          cmd.c_ld  = 1'b1;
          state_nxt = S_RDC;
        end
      end
      S_RDC: begin
        cmd.rd_c  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.kind == tscm_pkg::K_REG) begin
          if (sts.cur_st != tscm_pkg::ST_WRITING) begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = tscm_pkg::RS_WRONG_STATE;
            state_nxt   = S_DONE;
          end else begin
            cmd.cinfo_ld = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
        end else begin
          cmd.cinfo_ld = 1'b1;
          case (sts.cur_st)
            tscm_pkg::ST_FREE: state_nxt = S_TAKE;
            tscm_pkg::ST_OCCUPIED: begin
              cmd.key_ld   = 1'b1;
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: state_nxt = S_POP;
          endcase
        end
      end
      S_EVICT: begin
        cmd.wop   = tscm_pkg::WOP_UNMAP;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.wop   = tscm_pkg::WOP_TAKE;
        state_nxt = S_DONE;
      end
      S_APPLY: begin
        case (sts.kind)
          tscm_pkg::K_READ:    cmd.wop = tscm_pkg::WOP_READ;
          tscm_pkg::K_RELEASE: cmd.wop = tscm_pkg::WOP_RELEASE;
          tscm_pkg::K_UNREG:   cmd.wop = tscm_pkg::WOP_UNMAP;
          tscm_pkg::K_REG:     cmd.wop = tscm_pkg::WOP_REG;
          default:             cmd.wop = tscm_pkg::WOP_NONE;
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

endmodule

FILE: hdl/tile_slot_cache_manager_top.sv
// Top level of the tile slot cache manager: controller plus datapath.
// Depends on tscm_pkg, tscm_ctrl and tscm_datapath.
//
// channel   handshake            payload
// input     start & !busy        in_kind, in_resource_id, in_tile_id,
//                                in_slot_index, in_context_id
// result    out_strobe (1 cycle) out_status, out_slot_index_res, out_reader_count
//
// One transaction at a time; one result per transaction.
// Lookup, release and unregister are bounded by the key scan, which reads one
// slot of the slot memories per cycle. Register is bounded by a slot read and
// the key scan; a write request pops FIFO entries until one is usable, and
// scans the keys when the popped slot is occupied, to evict it.
// Reset is synchronous; the FIFO's initial contents need no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module tile_slot_cache_manager_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_resource_id,
  input  logic [63:0] in_tile_id,
  input  logic [5:0]  in_slot_index,
  input  logic [5:0]  in_context_id,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_index_res,
  output logic [5:0]  out_reader_count
);

  tscm_pkg::cmd_t cmd;
  tscm_pkg::sts_t sts;

  tscm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  tscm_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_resource_id     (in_resource_id),
    .in_tile_id         (in_tile_id),
    .in_slot_index      (in_slot_index),
    .in_context_id      (in_context_id),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_status),
    .out_slot_index_res (out_slot_index_res),
    .out_reader_count   (out_reader_count)
  );

endmodule
